### design/dq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types, constants and ring helpers for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

    // storage geometry
    localparam int DEPTH    = 64;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int SUM_W    = IDX_W + 1;
    localparam int DATA_W   = 32;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;

    // command queue between front and back
    localparam int CQ_DEPTH = 2;
    localparam int CQ_IDX_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

    // input kind codes
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DUMP_FWD   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DUMP_REV   = 3'd5;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    // decoded operation
    typedef enum logic [1:0] {
        OP_PUSH,
        OP_POP,
        OP_DUMP,
        OP_NOP
    } t_op;

    // decoded command: at_front selects the front end (push/pop)
    // or front-to-back order (dump)
    typedef struct packed {
        t_op                op;
        logic               at_front;
        logic [DATA_W-1:0]  value;
    } t_cmd;

    // command queue status seen by the front
    typedef struct packed {
        logic full;
        logic empty;
    } t_cq_stat;

    // back end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_DUMP
    } t_state;

    // ring position front + off, off below DEPTH
    function automatic t_idx ring_add(input t_idx front, input t_cnt off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(front) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return IDX_W'(sum);
    endfunction

    // ring position one before front
    function automatic t_idx ring_dec(input t_idx front);
        t_idx res;
        if (front == '0) begin
            res = IDX_W'(DEPTH - 1);
        end else begin
            res = front - 1'b1;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### design/dq_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_front
// Accepts input items and decodes the kind field into a queue command.
// ----------------------------------------------------------------------------
module dq_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [dq_pkg::KIND_W-1:0]  i_kind,
    input  wire logic [dq_pkg::DATA_W-1:0]  i_value,
    input  wire dq_pkg::t_cq_stat           i_cq_stat,
    output logic                            o_cq_push,
    output dq_pkg::t_cmd                    o_cq_cmd
);

    logic r_seen;
    logic n_seen;

    // stall only when the command queue has no room
    assign o_in_stall = i_cq_stat.full;
    assign o_cq_push  = i_in_valid && !i_cq_stat.full;

    // kind decode
    always_comb begin
        o_cq_cmd.value    = i_value;
        o_cq_cmd.at_front = 1'b0;
        o_cq_cmd.op       = dq_pkg::OP_NOP;
        case (i_kind)
            dq_pkg::KIND_PUSH_FRONT: begin
                o_cq_cmd.op       = dq_pkg::OP_PUSH;
                o_cq_cmd.at_front = 1'b1;
            end
            dq_pkg::KIND_PUSH_BACK: begin
                o_cq_cmd.op       = dq_pkg::OP_PUSH;
            end
            dq_pkg::KIND_POP_FRONT: begin
                o_cq_cmd.op       = dq_pkg::OP_POP;
                o_cq_cmd.at_front = 1'b1;
            end
            dq_pkg::KIND_POP_BACK: begin
                o_cq_cmd.op       = dq_pkg::OP_POP;
            end
            dq_pkg::KIND_DUMP_FWD: begin
                o_cq_cmd.op       = dq_pkg::OP_DUMP;
                o_cq_cmd.at_front = 1'b1;
            end
            dq_pkg::KIND_DUMP_REV: begin
                o_cq_cmd.op       = dq_pkg::OP_DUMP;
            end
            default: begin
                o_cq_cmd.op       = dq_pkg::OP_NOP;
            end
        endcase
    end

    // first-item flag after reset
    assign n_seen = r_seen || o_cq_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else begin
            r_seen <= n_seen;
        end
    end

`ifndef SYNTHESIS
    // nothing enters the queue while the input side is stalled
    a_no_push_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cq_push |-> !o_in_stall && r_seen == $past(n_seen))
        else $error("front pushed while stalled");
`endif

endmodule
`default_nettype wire

### design/dq_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_cmd_fifo
// Short command queue that decouples the decode front from the back end.
// ----------------------------------------------------------------------------
module dq_cmd_fifo (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire dq_pkg::t_cmd       i_cmd,
    input  wire logic               i_pop,
    output dq_pkg::t_cmd            o_cmd,
    output dq_pkg::t_cq_stat        o_stat
);

    dq_pkg::t_cmd                   r_buf [dq_pkg::CQ_DEPTH];
    logic [dq_pkg::CQ_IDX_W-1:0]    r_wr_ptr;
    logic [dq_pkg::CQ_IDX_W-1:0]    r_rd_ptr;
    logic [dq_pkg::CQ_CNT_W-1:0]    r_count;
    logic [dq_pkg::CQ_IDX_W-1:0]    n_wr_ptr;
    logic [dq_pkg::CQ_IDX_W-1:0]    n_rd_ptr;
    logic [dq_pkg::CQ_CNT_W-1:0]    n_count;

    assign o_stat.full  = (r_count == dq_pkg::CQ_CNT_W'(dq_pkg::CQ_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_cmd        = r_buf[r_rd_ptr];

    // pointer and fill updates
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == dq_pkg::CQ_IDX_W'(dq_pkg::CQ_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == dq_pkg::CQ_IDX_W'(dq_pkg::CQ_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_cmd;
        end
    end

`ifndef SYNTHESIS
    // never written when full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("command queue overflow");

    // never read when empty
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("command queue underflow");
`endif

endmodule
`default_nettype wire

### design/dq_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_back
// Executes queue commands on the ring store and drives the result register.
// ----------------------------------------------------------------------------
module dq_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire dq_pkg::t_cmd                   i_cmd,
    input  wire logic                           i_cmd_valid,
    output logic                                o_cmd_pop,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [dq_pkg::DATA_W-1:0]           o_data,
    output logic [dq_pkg::STATUS_W-1:0]         o_status,
    output logic                                o_last
);

    // ring store, read data registered
    logic [dq_pkg::DATA_W-1:0]      r_store [dq_pkg::DEPTH];
    logic [dq_pkg::DATA_W-1:0]      r_rd_data;

    dq_pkg::t_state                 r_state;
    dq_pkg::t_state                 n_state;
    dq_pkg::t_idx                   r_front;
    dq_pkg::t_idx                   n_front;
    dq_pkg::t_cnt                   r_count;
    dq_pkg::t_cnt                   n_count;
    dq_pkg::t_cnt                   r_pos;
    dq_pkg::t_cnt                   n_pos;
    logic                           r_fwd;
    logic                           n_fwd;

    logic                           r_out_valid;
    logic [dq_pkg::DATA_W-1:0]      r_out_data;
    logic [dq_pkg::STATUS_W-1:0]    r_out_status;
    logic                           r_out_last;

    logic                           out_free;
    logic                           q_empty;
    logic                           q_full;
    logic                           dump_last;
    logic                           take_cmd;
    logic                           wr_en;
    dq_pkg::t_idx                   wr_addr;
    logic                           rd_en;
    dq_pkg::t_idx                   rd_addr;
    logic                           load_out;
    logic [dq_pkg::DATA_W-1:0]      out_data;
    logic [dq_pkg::STATUS_W-1:0]    out_status;
    logic                           out_last;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign q_empty   = (r_count == '0);
    assign q_full    = (r_count == dq_pkg::CNT_W'(dq_pkg::DEPTH));
    assign dump_last = (r_pos == r_count - 1'b1);
    assign take_cmd  = (r_state == dq_pkg::ST_IDLE) && i_cmd_valid && out_free;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dq_pkg::ST_IDLE: begin
                if (take_cmd && !q_empty) begin
                    if (i_cmd.op == dq_pkg::OP_POP) begin
                        n_state = dq_pkg::ST_POP;
                    end else if (i_cmd.op == dq_pkg::OP_DUMP) begin
                        n_state = dq_pkg::ST_DUMP;
                    end
                end
            end
            dq_pkg::ST_POP: begin
                if (out_free) begin
                    n_state = dq_pkg::ST_IDLE;
                end
            end
            dq_pkg::ST_DUMP: begin
                if (out_free && dump_last) begin
                    n_state = dq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dq_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath control
    always_comb begin
        o_cmd_pop  = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = r_front;
        rd_en      = 1'b0;
        rd_addr    = r_front;
        load_out   = 1'b0;
        out_data   = '0;
        out_status = dq_pkg::STAT_OK;
        out_last   = 1'b1;
        n_front    = r_front;
        n_count    = r_count;
        n_pos      = r_pos;
        n_fwd      = r_fwd;
        case (r_state)
            dq_pkg::ST_IDLE: begin
                if (take_cmd) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.op)
                        dq_pkg::OP_PUSH: begin
                            load_out = 1'b1;
                            if (q_full) begin
                                out_status = dq_pkg::STAT_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + 1'b1;
                                if (i_cmd.at_front) begin
                                    wr_addr = dq_pkg::ring_dec(r_front);
                                    n_front = dq_pkg::ring_dec(r_front);
                                end else begin
                                    wr_addr = dq_pkg::ring_add(r_front, r_count);
                                end
                            end
                        end
                        dq_pkg::OP_POP: begin
                            if (q_empty) begin
                                load_out   = 1'b1;
                                out_status = dq_pkg::STAT_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                n_count = r_count - 1'b1;
                                if (i_cmd.at_front) begin
                                    rd_addr = r_front;
                                    n_front = dq_pkg::ring_add(r_front,
                                                               dq_pkg::CNT_W'(1));
                                end else begin
                                    rd_addr = dq_pkg::ring_add(r_front,
                                                               r_count - 1'b1);
                                end
                            end
                        end
                        dq_pkg::OP_DUMP: begin
                            if (q_empty) begin
                                load_out   = 1'b1;
                                out_status = dq_pkg::STAT_EMPTY;
                            end else begin
                                rd_en = 1'b1;
                                n_pos = '0;
                                n_fwd = i_cmd.at_front;
                                if (i_cmd.at_front) begin
                                    rd_addr = r_front;
                                end else begin
                                    rd_addr = dq_pkg::ring_add(r_front,
                                                               r_count - 1'b1);
                                end
                            end
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            dq_pkg::ST_POP: begin
                if (out_free) begin
                    load_out = 1'b1;
                    out_data = r_rd_data;
                end
            end
            dq_pkg::ST_DUMP: begin
                if (out_free) begin
                    load_out = 1'b1;
                    out_data = r_rd_data;
                    out_last = dump_last;
                    // fetch the next element while this one goes out
                    if (!dump_last) begin
                        rd_en = 1'b1;
                        n_pos = r_pos + 1'b1;
                        if (r_fwd) begin
                            rd_addr = dq_pkg::ring_add(r_front, r_pos + 1'b1);
                        end else begin
                            rd_addr = dq_pkg::ring_add(r_front,
                                                       r_count - 2'd2 - r_pos);
                        end
                    end
                end
            end
            default: begin
                load_out = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dq_pkg::ST_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_pos       <= '0;
            r_fwd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            r_pos   <= n_pos;
            r_fwd   <= n_fwd;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data   <= out_data;
            r_out_status <= out_status;
            r_out_last   <= out_last;
        end
    end

    // ring store write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr] <= i_cmd.value;
        end
        if (rd_en) begin
            r_rd_data <= r_store[rd_addr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data      = r_out_data;
    assign o_status    = r_out_status;
    assign o_last      = r_out_last;

`ifndef SYNTHESIS
    // occupancy stays within the ring
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= dq_pkg::CNT_W'(dq_pkg::DEPTH))
        else $error("element count out of range");

    // a waiting result is never overwritten
    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !load_out)
        else $error("stalled result overwritten");

    // a dump walk never runs past the stored elements
    a_dump_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dq_pkg::ST_DUMP) |-> (r_pos < r_count))
        else $error("dump position beyond element count");
`endif

endmodule
`default_nettype wire

### design/double_ended_queue_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded double-ended queue of signed 32-bit values held in a ring store.
// ----------------------------------------------------------------------------
// Each item carries a kind (push front/back, pop front/back, dump forward/
// reverse) and a value used by pushes. A decode front places commands into a
// two-entry command queue, and a back end executes them on a 64-entry ring
// memory with a registered read port, so input and output stall on their
// own. Push, failed pop, empty dump and unused kinds each give one result;
// a successful pop first reads the ring memory through its registered port;
// a dump of n elements gives n results, one per cycle from the read port
// while the output does not stall, last set on the final result. Results sit
// in an output register; the back end takes the next command in the cycle the
// waiting result leaves, and while results stall, up to two commands collect
// in the command queue before the input stalls.
// ----------------------------------------------------------------------------
module double_ended_queue_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [dq_pkg::KIND_W-1:0]      i_kind,
    input  wire logic signed [dq_pkg::DATA_W-1:0] i_value,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic signed [dq_pkg::DATA_W-1:0]    o_data,
    output logic [dq_pkg::STATUS_W-1:0]         o_status,
    output logic                                o_last
);

    dq_pkg::t_cq_stat   cq_stat;
    dq_pkg::t_cmd       cq_in_cmd;
    dq_pkg::t_cmd       cq_out_cmd;
    logic               cq_push;
    logic               cq_pop;
    logic [dq_pkg::DATA_W-1:0] back_data;

    // decode front
    dq_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_kind     (i_kind),
        .i_value    (i_value),
        .i_cq_stat  (cq_stat),
        .o_cq_push  (cq_push),
        .o_cq_cmd   (cq_in_cmd)
    );

    // command queue
    dq_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cq_push),
        .i_cmd   (cq_in_cmd),
        .i_pop   (cq_pop),
        .o_cmd   (cq_out_cmd),
        .o_stat  (cq_stat)
    );

    // execution back end
    dq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cq_out_cmd),
        .i_cmd_valid (!cq_stat.empty),
        .o_cmd_pop   (cq_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_data      (back_data),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    assign o_data = signed'(back_data);

endmodule
`default_nettype wire

### dv/double_ended_queue_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_core_test
// Self-checking bench for the bounded double-ended queue core.
// ----------------------------------------------------------------------------
// A local ring model predicts every result of each accepted command, and a
// checker compares each result leaving the core, field by field, against the
// oldest prediction. Directed commands cover the empty and full cases, the
// value extremes, single-element pops and the unused kind codes. Random
// commands with random contents then fill the queue to full, drain it, and
// mix all kinds. The sender idles in bursts, and the receiver stalls in
// changing patterns, with stretches of no stall at all.
// ----------------------------------------------------------------------------
module double_ended_queue_core_test;

    // kind codes the core ignores
    localparam logic [dq_pkg::KIND_W-1:0] KIND_SPARE_6 = 3'd6;
    localparam logic [dq_pkg::KIND_W-1:0] KIND_SPARE_7 = 3'd7;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int MAX_REPORTED   = 100;

    // receiver stall patterns
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    // one expected result
    typedef struct packed {
        logic [dq_pkg::DATA_W-1:0]   data;
        logic [dq_pkg::STATUS_W-1:0] status;
        logic                        last;
    } t_deq_result;

    logic                               i_clk       = 1'b0;
    logic                               i_rst_n     = 1'b0;
    logic                               i_in_valid  = 1'b0;
    logic [dq_pkg::KIND_W-1:0]          i_kind      = '0;
    logic signed [dq_pkg::DATA_W-1:0]   i_value     = '0;
    logic                               i_out_stall = 1'b0;
    logic                               o_in_stall;
    logic                               o_out_valid;
    logic signed [dq_pkg::DATA_W-1:0]   o_data;
    logic [dq_pkg::STATUS_W-1:0]        o_status;
    logic                               o_last;

    // local copy of the queue contents
    logic [dq_pkg::DATA_W-1:0] ring_copy [dq_pkg::DEPTH];
    int                head_pos   = 0;
    int                fill_level = 0;

    t_deq_result awaited_results [$];

    int mismatch_count  = 0;
    int results_checked = 0;
    int commands_sent   = 0;
    int full_hits       = 0;
    int empty_hits      = 0;
    int peak_fill       = 0;
    int burst_left      = 0;
    int idle_cycles     = 0;

    double_ended_queue_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_data      (o_data),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    always #5 i_clk = ~i_clk;

    // one mismatch line, capped so a broken core cannot flood the log
    task automatic report_mismatch(input string what,
                                   input logic [dq_pkg::DATA_W-1:0] got,
                                   input logic [dq_pkg::DATA_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTED) begin
            $display("mismatch at %0t ns: %s got %0h want %0h", $time, what, got, want);
        end
    endtask

    task automatic await_result(input logic [dq_pkg::DATA_W-1:0] data,
                                input logic [dq_pkg::STATUS_W-1:0] status,
                                input logic last);
        awaited_results.push_back({data, status, last});
    endtask

    // queue behavior for one accepted command
    task automatic predict_deque_command(input logic [dq_pkg::KIND_W-1:0] kind,
                                         input logic [dq_pkg::DATA_W-1:0] value);
        int pos;
        int off;
        case (kind)
            dq_pkg::KIND_PUSH_FRONT, dq_pkg::KIND_PUSH_BACK: begin
                if (fill_level == dq_pkg::DEPTH) begin
                    full_hits++;
                    await_result('0, dq_pkg::STAT_FULL, 1'b1);
                end else begin
                    if (kind == dq_pkg::KIND_PUSH_FRONT) begin
                        head_pos = (head_pos + dq_pkg::DEPTH - 1) % dq_pkg::DEPTH;
                        ring_copy[dq_pkg::IDX_W'(head_pos)] = value;
                    end else begin
                        ring_copy[dq_pkg::IDX_W'((head_pos + fill_level) % dq_pkg::DEPTH)]
                            = value;
                    end
                    fill_level++;
                    if (fill_level > peak_fill) peak_fill = fill_level;
                    await_result('0, dq_pkg::STAT_OK, 1'b1);
                end
            end
            dq_pkg::KIND_POP_FRONT, dq_pkg::KIND_POP_BACK: begin
                if (fill_level == 0) begin
                    empty_hits++;
                    await_result('0, dq_pkg::STAT_EMPTY, 1'b1);
                end else begin
                    if (kind == dq_pkg::KIND_POP_FRONT) begin
                        pos = head_pos;
                        head_pos = (head_pos + 1) % dq_pkg::DEPTH;
                    end else begin
                        pos = (head_pos + fill_level - 1) % dq_pkg::DEPTH;
                    end
                    fill_level--;
                    await_result(ring_copy[dq_pkg::IDX_W'(pos)], dq_pkg::STAT_OK, 1'b1);
                end
            end
            dq_pkg::KIND_DUMP_FWD, dq_pkg::KIND_DUMP_REV: begin
                if (fill_level == 0) begin
                    empty_hits++;
                    await_result('0, dq_pkg::STAT_EMPTY, 1'b1);
                end else begin
                    for (int i = 0; i < fill_level; i++) begin
                        off = (kind == dq_pkg::KIND_DUMP_FWD) ? i : fill_level - 1 - i;
                        await_result(
                            ring_copy[dq_pkg::IDX_W'((head_pos + off) % dq_pkg::DEPTH)],
                            dq_pkg::STAT_OK, i == fill_level - 1);
                    end
                end
            end
            default: begin
                await_result('0, dq_pkg::STAT_OK, 1'b1);
            end
        endcase
    endtask

    // drive one item, wait for acceptance, then maybe idle a while
    task automatic send_item(input logic [dq_pkg::KIND_W-1:0] kind,
                             input logic [dq_pkg::DATA_W-1:0] value);
        int gap;
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_value    <= value;
        do @(posedge i_clk); while (o_in_stall);
        predict_deque_command(kind, value);
        commands_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 10);
        end
    endtask

    // hold off the sender until every awaited result has come
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
    endtask

    // values biased toward the extremes
    function automatic logic [dq_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return '0;
            3: return '1;
            4: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [dq_pkg::KIND_W-1:0] pick_pop_kind();
        return $urandom_range(0, 1) ? dq_pkg::KIND_POP_FRONT : dq_pkg::KIND_POP_BACK;
    endfunction

    function automatic logic [dq_pkg::KIND_W-1:0] pick_push_kind();
        return $urandom_range(0, 1) ? dq_pkg::KIND_PUSH_FRONT : dq_pkg::KIND_PUSH_BACK;
    endfunction

    // empty cases, extremes, single element, unused kinds
    task automatic test_edge_cases();
        send_item(dq_pkg::KIND_POP_FRONT, 32'h1234_5678);
        send_item(dq_pkg::KIND_POP_BACK, '1);
        send_item(dq_pkg::KIND_DUMP_FWD, '0);
        send_item(dq_pkg::KIND_DUMP_REV, '0);
        send_item(dq_pkg::KIND_PUSH_FRONT, 32'h7fff_ffff);
        send_item(dq_pkg::KIND_PUSH_BACK, 32'h8000_0000);
        send_item(dq_pkg::KIND_PUSH_FRONT, '0);
        send_item(dq_pkg::KIND_PUSH_BACK, '1);
        send_item(dq_pkg::KIND_DUMP_FWD, $urandom);
        send_item(dq_pkg::KIND_DUMP_REV, $urandom);
        send_item(KIND_SPARE_6, $urandom);
        send_item(KIND_SPARE_7, $urandom);
        send_item(dq_pkg::KIND_POP_FRONT, '0);
        send_item(dq_pkg::KIND_POP_BACK, '0);
        send_item(dq_pkg::KIND_DUMP_FWD, '0);
        send_item(dq_pkg::KIND_POP_BACK, '0);
        send_item(dq_pkg::KIND_POP_FRONT, '0);
        send_item(dq_pkg::KIND_POP_BACK, '0);
        send_item(dq_pkg::KIND_PUSH_BACK, 32'h5555_5555);
        send_item(dq_pkg::KIND_DUMP_REV, '0);
        send_item(dq_pkg::KIND_POP_FRONT, '0);
        send_item(dq_pkg::KIND_PUSH_FRONT, 32'haaaa_aaaa);
        send_item(dq_pkg::KIND_DUMP_FWD, '0);
        send_item(dq_pkg::KIND_POP_BACK, '0);
        wait_for_drain();
    endtask

    // fill to full from random ends, push into full, dump, drain to empty
    task automatic test_fill_and_drain();
        while (fill_level < dq_pkg::DEPTH) send_item(pick_push_kind(), pick_value());
        send_item(dq_pkg::KIND_PUSH_FRONT, $urandom);
        send_item(dq_pkg::KIND_PUSH_BACK, $urandom);
        send_item(dq_pkg::KIND_DUMP_FWD, $urandom);
        send_item(dq_pkg::KIND_DUMP_REV, $urandom);
        send_item(pick_push_kind(), $urandom);
        while (fill_level > 0) send_item(pick_pop_kind(), $urandom);
        send_item(pick_pop_kind(), $urandom);
        wait_for_drain();
    endtask

    // random mix of every kind, a few unused codes as noise
    task automatic test_random_mix(input int count);
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 24)      send_item(dq_pkg::KIND_PUSH_FRONT, pick_value());
            else if (r < 48) send_item(dq_pkg::KIND_PUSH_BACK, pick_value());
            else if (r < 66) send_item(dq_pkg::KIND_POP_FRONT, $urandom);
            else if (r < 84) send_item(dq_pkg::KIND_POP_BACK, $urandom);
            else if (r < 91) send_item(dq_pkg::KIND_DUMP_FWD, $urandom);
            else if (r < 98) send_item(dq_pkg::KIND_DUMP_REV, $urandom);
            else send_item($urandom_range(0, 1) ? KIND_SPARE_6 : KIND_SPARE_7, $urandom);
        end
        wait_for_drain();
    endtask

    // receiver stall, switching pattern every so often
    always @(posedge i_clk) begin : stall_gen
        static t_stall_mode mode = STALL_NONE;
        static int          span = 50;
        static int          tick = 0;
        if (span == 0) begin
            mode = t_stall_mode'($urandom_range(0, 3));
            span = $urandom_range(20, 200);
        end else begin
            span--;
        end
        tick++;
        case (mode)
            STALL_NONE:     i_out_stall <= 1'b0;
            STALL_LIGHT:    i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    i_out_stall <= ($urandom_range(0, 3) != 0);
            default:        i_out_stall <= (tick % 5 < 2);
        endcase
    end

    // compare each result against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_deq_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("result with nothing awaited, data", o_data, '0);
            end else begin
                want = awaited_results.pop_front();
                results_checked++;
                if (o_data !== want.data) report_mismatch("data", o_data, want.data);
                if (o_status !== want.status) begin
                    report_mismatch("status", dq_pkg::DATA_W'(o_status),
                                    dq_pkg::DATA_W'(want.status));
                end
                if (o_last !== want.last) begin
                    report_mismatch("last", dq_pkg::DATA_W'(o_last),
                                    dq_pkg::DATA_W'(want.last));
                end
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("double_ended_queue_core verification failed");
            $finish;
        end
    end

    // reset, tests in turn, final verdict
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_edge_cases();
        test_fill_and_drain();
        test_random_mix(52);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("run covered %0d commands and %0d checked results, peak fill %0d of %0d",
                 commands_sent, results_checked, peak_fill, dq_pkg::DEPTH);
        $display("full pushes %0d, empty pops or dumps %0d, mismatches %0d",
                 full_hits, empty_hits, mismatch_count);
        if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("double_ended_queue_core verification clean");
        end else begin
            $display("double_ended_queue_core verification failed");
        end
        $finish;
    end

endmodule

### double_ended_queue_core.f
design/dq_pkg.sv
design/dq_front.sv
design/dq_cmd_fifo.sv
design/dq_back.sv
design/double_ended_queue_core.sv
dv/double_ended_queue_core_test.sv
